### hw/rtl/gsnd_pkg.sv
package gsnd_pkg;

    localparam int ID_W             = 10;
    localparam int TARGET_W         = 7;
    localparam int EDGE_W           = 32;
    localparam int VERTEX_COUNT_DEF = 1024;
    localparam int MAX_NB_DEF       = 64;

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(8);

endpackage

### hw/rtl/gsnd_if.sv
interface gsnd_edge_if import gsnd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] first_vertex;
    logic [ID_W-1:0] second_vertex;
    logic            end_of_stream;

    modport source (output valid, output first_vertex, output second_vertex,
                    output end_of_stream, input ready);
    modport sink   (input valid, input first_vertex, input second_vertex,
                    input end_of_stream, output ready);
endinterface

interface gsnd_result_if import gsnd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   root_vertex;
    logic [ID_W-1:0]   neighbour_vertex;
    logic [EDGE_W-1:0] edge_index;
    logic              found;
    logic              last_result;

    modport source (output valid, output root_vertex, output neighbour_vertex,
                    output edge_index, output found, output last_result, input ready);
    modport sink   (input valid, input root_vertex, input neighbour_vertex,
                    input edge_index, input found, input last_result, output ready);
endinterface

### hw/rtl/gsnd_ram.sv
module gsnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/gsnd_slot.sv
// id modulo VERTEX_COUNT: reciprocal multiply, then multiply back and subtract.
// Two-stage pipeline.
module gsnd_slot import gsnd_pkg::*; #(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic [ID_W-1:0]                 i_id,
    output logic [$clog2(VERTEX_COUNT)-1:0] o_slot
);

    localparam int     SLOT_W = $clog2(VERTEX_COUNT);
    localparam int     SH     = ID_W + SLOT_W;
    localparam longint RECIP  = ((longint'(1) << SH) + longint'(VERTEX_COUNT) - 1)
                                / longint'(VERTEX_COUNT);
    localparam int     MUL_W  = ID_W + 2;
    localparam int     PROD_W = ID_W + MUL_W;
    localparam int     QD_W   = ID_W + SLOT_W + 1;

    logic [PROD_W-1:0] w_prod;
    logic [QD_W-1:0]   w_qd;
    logic [ID_W-1:0]   r_q;
    logic [ID_W-1:0]   r_id;
    logic [SLOT_W-1:0] r_slot;

    assign w_prod = PROD_W'(i_id) * PROD_W'(RECIP);
    assign w_qd   = QD_W'(r_q) * QD_W'(VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        r_q    <= ID_W'(w_prod >> SH);
        r_id   <= i_id;
        r_slot <= SLOT_W'(QD_W'(r_id) - w_qd);
    end

    assign o_slot = r_slot;

endmodule

### hw/rtl/graph_stream_neighbourhood_detector.sv
// Neighbourhood detector for a stream of undirected edges.
// i_edge (valid/ready) takes one edge per beat: two vertex ids and an
// end-of-stream flag. o_result (valid/ready) gives one beat per neighbour of
// the first vertex whose deduplicated list reaches the target size (list
// order, last_result on the final beat), or one beat with found low when the
// end-of-stream edge detects nothing. After that, edges are taken and dropped
// until reset. i_cfg_wr_en/i_cfg_wr_data set the target size.
// An edge goes through slot computation (S_MOD0 to S_MOD3), then two list
// updates, each scanning the owner's list with one list RAM read per cycle
// and appending the other vertex if absent and the list is not full, then a
// count check of the first vertex and, if it falls short, of the second. A
// result beat is loaded (S_E_RD, S_E_LOAD) only after the previous one is
// taken; the beat is held in the output register while ready is low.
// Reset is synchronous; afterwards the count RAM is cleared one entry per
// cycle, all VERTEX_COUNT entries, during which no edge is taken (configuration
// writes are).
module graph_stream_neighbourhood_detector import gsnd_pkg::*; #(
    parameter int VERTEX_COUNT   = VERTEX_COUNT_DEF,
    parameter int MAX_NEIGHBOURS = MAX_NB_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [TARGET_W-1:0] i_cfg_wr_data,
    gsnd_edge_if.sink           i_edge,
    gsnd_result_if.source       o_result
);

    localparam int SLOT_W     = $clog2(VERTEX_COUNT);
    localparam int CNT_W      = $clog2(MAX_NEIGHBOURS + 1);
    localparam int LIST_DEPTH = VERTEX_COUNT * MAX_NEIGHBOURS;
    localparam int LIST_AW    = $clog2(LIST_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_MOD0, S_MOD1, S_MOD2, S_MOD3, S_CNT_RD, S_CNT_WAIT,
        S_SCAN, S_APPEND, S_E_RD, S_E_LOAD, S_E_SEND
    } t_state;

    t_state              r_state;
    logic [TARGET_W-1:0] r_target;
    logic                r_clr_busy;
    logic [SLOT_W-1:0]   r_clr_addr;
    logic                r_done;
    logic [EDGE_W-1:0]   r_edges;
    logic [ID_W-1:0]     r_a;
    logic [ID_W-1:0]     r_b;
    logic                r_eos;
    logic [SLOT_W-1:0]   r_slot_a;
    logic [SLOT_W-1:0]   r_slot_b;
    logic [1:0]          r_phase;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_idx;
    logic                r_chk;
    logic                r_out_valid;
    logic [ID_W-1:0]     r_out_root;
    logic [ID_W-1:0]     r_out_nb;
    logic [EDGE_W-1:0]   r_out_edge;
    logic                r_out_found;
    logic                r_out_last;

    logic                w_accept;
    logic [ID_W-1:0]     w_slot_id;
    logic [SLOT_W-1:0]   w_slot;
    logic [SLOT_W-1:0]   w_owner_slot;
    logic [ID_W-1:0]     w_owner;
    logic [ID_W-1:0]     w_other;
    logic [LIST_AW-1:0]  w_base;
    logic [LIST_AW-1:0]  w_list_rd_addr;
    logic [LIST_AW-1:0]  w_list_wr_addr;
    logic                w_list_we;
    logic [ID_W-1:0]     w_list_rd_data;
    logic                w_cnt_we;
    logic [SLOT_W-1:0]   w_cnt_wr_addr;
    logic [CNT_W-1:0]    w_cnt_wr_data;
    logic [CNT_W-1:0]    w_cnt_rd_data;
    logic                w_full;
    logic                w_hit;
    logic                w_cnt_ge;
    logic                w_last_beat;

    assign i_edge.ready = (r_state == S_IDLE) && !r_clr_busy;
    assign w_accept     = i_edge.valid && i_edge.ready;

    assign w_slot_id    = (r_state == S_MOD0) ? r_a : r_b;
    assign w_owner_slot = r_phase[0] ? r_slot_b : r_slot_a;
    assign w_owner      = r_phase[0] ? r_b : r_a;
    assign w_other      = r_phase[0] ? r_a : r_b;

    assign w_base         = LIST_AW'(LIST_AW'(w_owner_slot) * LIST_AW'(MAX_NEIGHBOURS));
    assign w_list_rd_addr = w_base + LIST_AW'(r_idx);
    assign w_list_wr_addr = w_base + LIST_AW'(r_n);

    assign w_full        = (r_n == CNT_W'(MAX_NEIGHBOURS));
    assign w_list_we     = (r_state == S_APPEND) && !w_full;
    assign w_cnt_we      = r_clr_busy || w_list_we;
    assign w_cnt_wr_addr = r_clr_busy ? r_clr_addr : w_owner_slot;
    assign w_cnt_wr_data = r_clr_busy ? '0 : r_n + CNT_W'(1);

    assign w_hit       = r_chk && (w_list_rd_data == w_other);
    assign w_cnt_ge    = TARGET_W'(w_cnt_rd_data) >= r_target;
    assign w_last_beat = (r_idx + CNT_W'(1)) == r_n;

    gsnd_slot #(
        .VERTEX_COUNT(VERTEX_COUNT)
    ) u_slot (
        .i_clk  (i_clk),
        .i_id   (w_slot_id),
        .o_slot (w_slot)
    );

    gsnd_ram #(
        .WIDTH(CNT_W),
        .DEPTH(VERTEX_COUNT)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cnt_we),
        .i_wr_addr (w_cnt_wr_addr),
        .i_wr_data (w_cnt_wr_data),
        .i_rd_addr (w_owner_slot),
        .o_rd_data (w_cnt_rd_data)
    );

    gsnd_ram #(
        .WIDTH(ID_W),
        .DEPTH(LIST_DEPTH)
    ) u_list_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_list_we),
        .i_wr_addr (w_list_wr_addr),
        .i_wr_data (w_other),
        .i_rd_addr (w_list_rd_addr),
        .o_rd_data (w_list_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= TARGET_RESET;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_done      <= 1'b0;
            r_edges     <= '0;
            r_phase     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
                if (r_clr_addr == SLOT_W'(VERTEX_COUNT - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && !r_done) begin
                        r_a     <= i_edge.first_vertex;
                        r_b     <= i_edge.second_vertex;
                        r_eos   <= i_edge.end_of_stream;
                        r_phase <= '0;
                        if (r_edges != '1) begin
                            r_edges <= r_edges + EDGE_W'(1);
                        end
                        r_state <= S_MOD0;
                    end
                end
                S_MOD0: r_state <= S_MOD1;
                S_MOD1: r_state <= S_MOD2;
                S_MOD2: begin
                    r_slot_a <= w_slot;
                    r_state  <= S_MOD3;
                end
                S_MOD3: begin
                    r_slot_b <= w_slot;
                    r_state  <= S_CNT_RD;
                end
                S_CNT_RD: r_state <= S_CNT_WAIT;
                S_CNT_WAIT: begin
                    r_n   <= w_cnt_rd_data;
                    r_idx <= '0;
                    r_chk <= 1'b0;
                    if (!r_phase[1]) begin
                        r_state <= S_SCAN;
                    end else if (w_cnt_ge) begin
                        r_done  <= 1'b1;
                        r_state <= S_E_RD;
                    end else if (!r_phase[0]) begin
                        r_phase <= r_phase + 2'd1;
                        r_state <= S_CNT_RD;
                    end else if (r_eos) begin
                        r_done      <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_out_root  <= '0;
                        r_out_nb    <= '0;
                        r_out_edge  <= r_edges;
                        r_out_found <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_E_SEND;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_phase <= r_phase + 2'd1;
                        r_state <= S_CNT_RD;
                    end else if (r_idx < r_n) begin
                        r_idx <= r_idx + CNT_W'(1);
                        r_chk <= 1'b1;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    r_phase <= r_phase + 2'd1;
                    r_state <= S_CNT_RD;
                end
                S_E_RD: r_state <= S_E_LOAD;
                S_E_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_out_root  <= w_owner;
                    r_out_nb    <= w_list_rd_data;
                    r_out_edge  <= r_edges;
                    r_out_found <= 1'b1;
                    r_out_last  <= w_last_beat;
                    r_idx       <= r_idx + CNT_W'(1);
                    r_state     <= S_E_SEND;
                end
                S_E_SEND: begin
                    if (o_result.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_out_last ? S_IDLE : S_E_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.root_vertex      = r_out_root;
    assign o_result.neighbour_vertex = r_out_nb;
    assign o_result.edge_index       = r_out_edge;
    assign o_result.found            = r_out_found;
    assign o_result.last_result      = r_out_last;

endmodule

### sim/graph_stream_neighbourhood_detector_test.sv
module graph_stream_neighbourhood_detector_test;
    import gsnd_pkg::*;

    localparam int NB_LIMIT     = MAX_NB_DEF;
    localparam int VCOUNT       = VERTEX_COUNT_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_EDGES = 360;
    localparam int TAIL_EDGES   = 20;

    typedef struct {
        logic [ID_W-1:0]   root_vertex;
        logic [ID_W-1:0]   neighbour_vertex;
        logic [EDGE_W-1:0] edge_index;
        logic              found;
        logic              last_result;
    } t_result_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_wr_en;
    logic [TARGET_W-1:0] cfg_wr_data;

    gsnd_edge_if   edge_bus ();
    gsnd_result_if result_bus ();

    graph_stream_neighbourhood_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_edge        (edge_bus),
        .o_result      (result_bus)
    );

    // neighbourhood predictor state
    logic [TARGET_W-1:0] target_size;
    int                  nb_count [VCOUNT];
    logic [ID_W-1:0]     nb_list  [VCOUNT][NB_LIMIT];
    logic [EDGE_W-1:0]   edges_counted;
    bit                  run_closed;

    t_result_beat        pending_beats [$];
    int                  mismatches;
    int                  cycle_count;
    bit                  bursts_on;
    logic [ID_W-1:0]     hubs [3];
    logic [ID_W-1:0]     dense_pool [16];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void link_vertex(logic [ID_W-1:0] owner, logic [ID_W-1:0] other);
        for (int i = 0; i < nb_count[owner]; i++) begin
            if (nb_list[owner][i] == other) return;
        end
        if (nb_count[owner] >= NB_LIMIT) return;
        nb_list[owner][nb_count[owner]] = other;
        nb_count[owner]++;
    endfunction

    function automatic void report_neighbourhood(logic [ID_W-1:0] root);
        for (int i = 0; i < nb_count[root]; i++) begin
            pending_beats.push_back('{root_vertex: root,
                                      neighbour_vertex: nb_list[root][i],
                                      edge_index: edges_counted,
                                      found: 1'b1,
                                      last_result: (i == nb_count[root] - 1)});
        end
        run_closed = 1'b1;
    endfunction

    function automatic void apply_edge(logic [ID_W-1:0] a, logic [ID_W-1:0] b, logic eos);
        if (run_closed) return;
        if (edges_counted != '1) edges_counted++;
        link_vertex(a, b);
        link_vertex(b, a);
        if (nb_count[a] >= target_size) begin
            report_neighbourhood(a);
        end else if (nb_count[b] >= target_size) begin
            report_neighbourhood(b);
        end else if (eos) begin
            pending_beats.push_back('{root_vertex: '0, neighbour_vertex: '0,
                                      edge_index: edges_counted, found: 1'b0,
                                      last_result: 1'b1});
            run_closed = 1'b1;
        end
    endfunction

    function automatic void compare_field(string name, logic [EDGE_W-1:0] want,
                                          logic [EDGE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result_beat want;
        if (i_rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected result beat: root %0d neighbour %0d",
                       result_bus.root_vertex, result_bus.neighbour_vertex);
                mismatches++;
            end else begin
                want = pending_beats.pop_front();
                compare_field("root_vertex", EDGE_W'(want.root_vertex),
                              EDGE_W'(result_bus.root_vertex));
                compare_field("neighbour_vertex", EDGE_W'(want.neighbour_vertex),
                              EDGE_W'(result_bus.neighbour_vertex));
                compare_field("edge_index", want.edge_index, result_bus.edge_index);
                compare_field("found", EDGE_W'(want.found), EDGE_W'(result_bus.found));
                compare_field("last_result", EDGE_W'(want.last_result),
                              EDGE_W'(result_bus.last_result));
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int stall_left;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            result_bus.ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_edge(logic [ID_W-1:0] a, logic [ID_W-1:0] b, logic eos);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            edge_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        edge_bus.valid         <= 1'b1;
        edge_bus.first_vertex  <= a;
        edge_bus.second_vertex <= b;
        edge_bus.end_of_stream <= eos;
        do @(posedge i_clk); while (edge_bus.ready !== 1'b1);
        apply_edge(a, b, eos);
    endtask

    // block idle: all beats in, then room for a result-free edge to finish
    task automatic settle();
        edge_bus.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(logic [TARGET_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        target_size = value;
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_register_writes();
        write_target('0);
        write_target(TARGET_W'(1));
        write_target(TARGET_W'(NB_LIMIT));
        write_target('1);
    endtask

    // target above any list size: nothing can be detected here
    task automatic test_directed_edges();
        send_edge('0, '0, 1'b0);
        send_edge('1, '1, 1'b0);
        send_edge('0, '1, 1'b0);
        send_edge('1, '0, 1'b0);
        send_edge('0, '1, 1'b0);
        send_edge(10'h155, 10'h2AA, 1'b0);
        send_edge(10'h2AA, 10'h155, 1'b0);
        send_edge(10'h200, 10'h1FF, 1'b0);
        send_edge(10'd1, 10'd2, 1'b0);
        send_edge(10'd2, 10'd1, 1'b0);
        send_edge(10'd1, 10'd1, 1'b0);
        send_edge(10'd1, 10'd3, 1'b0);
        send_edge(10'd3, 10'd2, 1'b0);
        send_edge('0, 10'd1, 1'b0);
        send_edge(10'd1, '1, 1'b0);
        send_edge(10'h2AA, 10'h2AA, 1'b0);
        settle();
    endtask

    task automatic test_random_stream();
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        int              kind;
        hubs[0] = ID_W'($urandom_range(0, VCOUNT - 1));
        hubs[1] = hubs[0] + ID_W'($urandom_range(1, VCOUNT - 1));
        hubs[2] = ID_W'($urandom_range(0, VCOUNT - 1));
        foreach (dense_pool[i]) dense_pool[i] = ID_W'($urandom_range(0, VCOUNT - 1));
        for (int n = 0; n < RANDOM_EDGES; n++) begin
            if (n % 60 == 0) bursts_on = ((n / 60) % 3 != 2);
            if (n == RANDOM_EDGES / 2) begin
                settle();
                write_target(TARGET_W'(NB_LIMIT + 1));
            end
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                // star edge around a hub, either orientation
                a = hubs[$urandom_range(0, 2)];
                b = ID_W'($urandom_range(0, VCOUNT - 1));
                if ($urandom_range(0, 1)) {a, b} = {b, a};
            end else if (kind < 8) begin
                a = dense_pool[$urandom_range(0, 15)];
                b = dense_pool[$urandom_range(0, 15)];
            end else if (kind == 8) begin
                a = ID_W'($urandom_range(0, VCOUNT - 1));
                b = a;
            end else begin
                a = ID_W'($urandom_range(0, VCOUNT - 1));
                b = ID_W'($urandom_range(0, VCOUNT - 1));
            end
            send_edge(a, b, 1'b0);
        end
    endtask

    // fill two hubs, then one edge where both reach the target: its first vertex wins
    task automatic test_detection();
        bursts_on = 1'b1;
        for (int h = 0; h < 2; h++) begin
            while (nb_count[hubs[h]] < NB_LIMIT) begin
                send_edge(hubs[h], ID_W'($urandom_range(0, VCOUNT - 1)), 1'b0);
            end
        end
        settle();
        write_target(TARGET_W'(NB_LIMIT));
        send_edge(hubs[1], hubs[0], 1'b1);
    endtask

    task automatic test_ignored_tail();
        settle();
        bursts_on = 1'b0;
        for (int n = 0; n < TAIL_EDGES; n++) begin
            send_edge(ID_W'($urandom_range(0, VCOUNT - 1)),
                      ID_W'($urandom_range(0, VCOUNT - 1)),
                      1'($urandom_range(0, 1)));
        end
        settle();
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        cfg_wr_en              <= 1'b0;
        cfg_wr_data            <= '0;
        edge_bus.valid         <= 1'b0;
        edge_bus.first_vertex  <= '0;
        edge_bus.second_vertex <= '0;
        edge_bus.end_of_stream <= 1'b0;
        mismatches    = 0;
        cycle_count   = 0;
        bursts_on     = 1'b1;
        target_size   = TARGET_RESET;
        edges_counted = '0;
        run_closed    = 1'b0;
        foreach (nb_count[i]) nb_count[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_writes();
        test_directed_edges();
        test_random_stream();
        test_detection();
        test_ignored_tail();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
